// File: hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_PRIORITY = 3'd1;
  localparam logic [2:0] ST_EMPTY        = 3'd2;
  localparam logic [2:0] ST_NO_EXACT     = 3'd3;
  localparam logic [2:0] ST_NONE_WITHIN  = 3'd4;
  localparam logic [2:0] ST_FULL         = 3'd5;

  // tuser encoding of the request word
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } spq_op_e;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] value;
  } entry_t;

endpackage

// File: hw/rtl/sorted_priority_queue_core.sv
// Channel  Dir  tdata (low bit up)                        tuser
// s_axis   in   data_value[31:0], priority_key[47:32]     op[0]
// m_axis   out  removed_value[31:0], entry_count[36:32]   status[2:0]
//
// Rejected inserts and removes from an empty queue go straight from idle to completion.
// Insert walks down from the tail, shifting entries of higher priority up one slot.
// Remove walks the whole queue once.
// The walk is set by the single slot RAM: one read and one write per cycle.
// Reset clears the count, the state and the output valid; slot contents need no clearing.
// A finished word waits in the output register; a new word is taken meanwhile.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // data_value[31:0], priority_key[47:32]
  input  logic [0:0]  s_axis_tuser_i,   // op[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // removed_value[31:0], entry_count[36:32]
  output logic [2:0]  m_axis_tuser_o    // status[2:0]
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_REM      = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [15:0]      key_q, key_d;
  logic [31:0]      value_q, value_d;
  logic             found_q, found_d;
  logic [31:0]      taken_q, taken_d;
  logic [2:0]       status_q, status_d;

  logic             m_valid_q, m_valid_d;
  logic [2:0]       out_status_q, out_status_d;
  logic [31:0]      out_value_q, out_value_d;
  logic [4:0]       out_count_q, out_count_d;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic [15:0]      key_in;
  logic [31:0]      value_in;
  logic             in_bad;
  logic [CNT_W-1:0] held_m1;
  logic [IDX_W-1:0] last_idx;
  logic [16:0]      key_mag;
  logic             rem_match;
  entry_t           new_entry;
  logic [CNT_W+4:0] held_ext;

  assign key_in    = s_axis_tdata_i[47:32];
  assign value_in  = s_axis_tdata_i[31:0];
  assign in_bad    = (key_in[15:8] != 8'd0) || (key_in[7:0] == 8'd0);
  assign held_m1   = held_q - CNT_W'(1);
  assign last_idx  = held_m1[IDX_W-1:0];
  assign new_entry = '{prio: key_q[7:0], value: value_q};
  assign held_ext  = {5'd0, held_q};

  // limit of a negative key; the most negative key gives 32768
  assign key_mag   = 17'd0 - {key_q[15], key_q};
  assign rem_match = (key_q == 16'd0) ||
                     (!key_q[15] && key_q[15:8] == 8'd0 && key_q[7:0] == ram_rdata.prio) ||
                     (key_q[15] && ({9'd0, ram_rdata.prio} <= key_mag));

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    ridx_d    = ridx_q;
    key_d     = key_q;
    value_d   = value_q;
    found_d   = found_q;
    taken_d   = taken_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    m_valid_d    = m_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          key_d   = key_in;
          value_d = value_in;
          found_d = 1'b0;
          taken_d = 32'd0;
          if (s_axis_tuser_i[0] == OP_INSERT) begin
            if (in_bad) begin
              status_d = ST_BAD_PRIORITY;
              state_d  = S_DONE;
            end else if (held_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else if (held_q == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{prio: key_in[7:0], value: value_in};
              held_d    = held_q + CNT_W'(1);
              status_d  = ST_OK;
              state_d   = S_DONE;
            end else begin
              // walk down from the tail, shifting larger priorities up
              ram_re    = 1'b1;
              ram_raddr = last_idx;
              ridx_d    = last_idx;
              state_d   = S_INS;
            end
          end else begin
            if (held_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              ridx_d    = '0;
              state_d   = S_REM;
            end
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ridx_q + IDX_W'(1);
        if (ram_rdata.prio > key_q[7:0]) begin
          ram_wdata = ram_rdata;
          if (ridx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ridx_q - IDX_W'(1);
            ridx_d    = ridx_q - IDX_W'(1);
          end
        end else begin
          ram_wdata = new_entry;
          held_d    = held_q + CNT_W'(1);
          status_d  = ST_OK;
          state_d   = S_DONE;
        end
      end
      S_INS_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_entry;
        held_d    = held_q + CNT_W'(1);
        status_d  = ST_OK;
        state_d   = S_DONE;
      end
      S_REM: begin
        if (!found_q && rem_match) begin
          found_d = 1'b1;
          taken_d = ram_rdata.value;
        end else if (found_q) begin
          // close the gap behind the removed entry
          ram_we    = 1'b1;
          ram_waddr = ridx_q - IDX_W'(1);
          ram_wdata = ram_rdata;
        end
        if (ridx_q == last_idx) begin
          state_d = S_DONE;
          if (found_q || rem_match) begin
            held_d   = held_m1;
            status_d = ST_OK;
          end else if (key_q[15]) begin
            status_d = ST_NONE_WITHIN;
          end else begin
            status_d = ST_NO_EXACT;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ridx_q + IDX_W'(1);
          ridx_d    = ridx_q + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d    = 1'b1;
          out_status_d = status_q;
          out_value_d  = taken_q;
          out_count_d  = held_ext[4:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    key_q        <= key_d;
    value_q      <= value_d;
    found_q      <= found_d;
    taken_q      <= taken_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  spq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_count_q, out_value_q};
  assign m_axis_tuser_o  = out_status_q;

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == $past(held_q)) || (held_q == $past(held_q) + CNT_W'(1)) ||
    (held_q == $past(held_q) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_held_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != $past(held_q)) |-> (state_q == S_DONE))
    else $error("entry count changed outside completion");

  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot read and write hit the same entry");

  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_status_q != ST_OK) |-> (out_value_q == 32'd0))
    else $error("failed item carries a removed value");
`endif

endmodule

// File: hw/rtl/spq_ram.sv
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/spq_tb_pkg.sv
`timescale 1ns / 100ps
package spq_tb_pkg;

  // expected fields of one result word
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [4:0]  count;
  } outcome_t;

endpackage

// File: verif/spq_checker.sv
`timescale 1ns / 100ps
module spq_checker
  import spq_pkg::*;
  import spq_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [47:0] s_data_i,
  input  logic [0:0]  s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  input  logic [2:0]  m_user_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned peak_o,
  output logic [5:0]  status_seen_o
);

  // shadow copy of the queue, slots 0..held_len-1 in service order
  logic [31:0] held_value [CAPACITY];
  logic [7:0]  held_prio  [CAPACITY];
  int unsigned held_len;
  outcome_t    outcome_q [$];

  function automatic outcome_t apply_word(spq_op_e op, logic [31:0] value,
                                          logic signed [15:0] key);
    outcome_t    r;
    int          k;
    int unsigned pos;
    logic [7:0]  pr;
    r   = '0;
    k   = key;
    pos = 0;
    if (op == OP_INSERT) begin
      if (k < 1 || k > 255) begin
        r.status = ST_BAD_PRIORITY;
      end else if (held_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        pr = k[7:0];
        // new entry goes behind everything of equal or lower priority
        while (pos < held_len && held_prio[pos] <= pr) pos++;
        for (int unsigned i = held_len; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[pos] = value;
        held_prio[pos]  = pr;
        held_len++;
        r.status = ST_OK;
      end
    end else if (held_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      if (k > 0) begin
        while (pos < held_len && int'(held_prio[pos]) != k) pos++;
      end else if (k < 0) begin
        // negative key is an upper bound on priority
        while (pos < held_len && int'(held_prio[pos]) > -k) pos++;
      end
      if (pos >= held_len) begin
        r.status = (k > 0) ? ST_NO_EXACT : ST_NONE_WITHIN;
      end else begin
        r.value = held_value[pos];
        for (int unsigned i = pos; i + 1 < held_len; i++) begin
          held_value[i] = held_value[i+1];
          held_prio[i]  = held_prio[i+1];
        end
        held_len--;
        r.status = ST_OK;
      end
    end
    r.count = held_len[4:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      held_len      = 0;
      outcome_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      checked_o     = 0;
      peak_o        = 0;
      status_seen_o = '0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing pending: status %0d value %h count %0d",
                 m_user_i, m_data_i[31:0], m_data_i[36:32]);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          checked_o++;
          if (m_user_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_user_i);
            fail_count_o++;
          end
          if (m_data_i[31:0] !== want.value) begin
            $error("removed_value: expected %h, got %h", want.value, m_data_i[31:0]);
            fail_count_o++;
          end
          if (m_data_i[36:32] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_data_i[36:32]);
            fail_count_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        want = apply_word(spq_op_e'(s_user_i), s_data_i[31:0], s_data_i[47:32]);
        outcome_q.push_back(want);
        status_seen_o[want.status] = 1'b1;
        if (held_len > peak_o) peak_o = held_len;
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  localparam int unsigned STALL_MAX    = 19;
  localparam int unsigned RANDOM_WORDS = 750;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [47:0] s_data;
  logic [0:0]  s_user;
  logic        m_valid;
  logic        m_ready;
  logic [39:0] m_data;
  logic [2:0]  m_user;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned peak;
  logic [5:0]  status_seen;

  bit tx_quiet;
  bit rx_quiet;

  sorted_priority_queue_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  spq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_valid),
    .s_ready_i     (s_ready),
    .s_data_i      (s_data),
    .s_user_i      (s_user),
    .m_valid_i     (m_valid),
    .m_ready_i     (m_ready),
    .m_data_i      (m_data),
    .m_user_i      (m_user),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .peak_o        (peak),
    .status_seen_o (status_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // drive one request word, then hold it until taken
  task automatic push_word(spq_op_e op, logic [31:0] value, int key);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {16'(key), value};
    s_user  <= op;
    do @(posedge clk_i); while (!(s_valid && s_ready));
  endtask

  task automatic drain_queue();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly a handful of priorities so ties and exact hits are common
  function automatic int insert_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 4) return -int'($urandom_range(1, 32768));
    if (r < 6) return int'($urandom_range(256, 32767));
    if (r < 70) return int'($urandom_range(1, 6));
    if (r < 80) return r[0] ? 1 : 255;
    return int'($urandom_range(1, 255));
  endfunction

  function automatic int remove_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 0;
    if (r < 65) return int'($urandom_range(1, 8));
    if (r < 72) return int'($urandom_range(1, 32767));
    if (r < 90) return -int'($urandom_range(1, 8));
    if (r < 95) return -int'($urandom_range(1, 255));
    return -int'($urandom_range(1, 32768));
  endfunction

  initial begin : sink
    int unsigned rx_hold;
    m_ready = 1'b0;
    rx_hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) rx_hold = rx_quiet ? 0 : $urandom_range(0, STALL_MAX);
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_ready <= 1'b0;
        rx_hold--;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned ins_pct;
    s_valid  = 1'b0;
    s_data   = '0;
    s_user   = OP_INSERT;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_ni   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, rejected priorities, extremes and tie order
    push_word(OP_REMOVE, 32'h1234_5678, 0);
    push_word(OP_REMOVE, 32'h0000_0000, -32768);
    push_word(OP_REMOVE, 32'h0000_0000, 5);
    push_word(OP_INSERT, 32'hdead_beef, 0);
    push_word(OP_INSERT, 32'hdead_beef, -1);
    push_word(OP_INSERT, 32'hdead_beef, 256);
    push_word(OP_INSERT, 32'hdead_beef, -32768);
    push_word(OP_INSERT, 32'hdead_beef, 32767);
    push_word(OP_INSERT, 32'h7fff_ffff, 255);
    push_word(OP_INSERT, 32'h8000_0000, 1);
    push_word(OP_INSERT, 32'hffff_ffff, 255);
    push_word(OP_INSERT, 32'h0000_0000, 128);
    push_word(OP_INSERT, 32'h5555_aaaa, 1);
    push_word(OP_REMOVE, 32'h0000_0000, 300);
    push_word(OP_REMOVE, 32'h0000_0000, 2);
    push_word(OP_REMOVE, 32'h0000_0000, -1);
    push_word(OP_REMOVE, 32'h0000_0000, 255);
    push_word(OP_REMOVE, 32'h0000_0000, -32768);
    push_word(OP_REMOVE, 32'h0000_0000, -127);
    push_word(OP_REMOVE, 32'h0000_0000, 0);
    push_word(OP_REMOVE, 32'h0000_0000, 32767);
    push_word(OP_REMOVE, 32'h0000_0000, 0);
    drain_queue();

    // phases swing between filling and emptying; the first one fills up
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      case (phase % 4)
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        2:       ins_pct = 15;
        default: ins_pct = $urandom_range(30, 70);
      endcase
      tx_quiet  = ($urandom_range(0, 3) == 0);
      rx_quiet  = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 60);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < ins_pct) push_word(OP_INSERT, $urandom, insert_key());
        else push_word(OP_REMOVE, $urandom, remove_key());
        sent++;
      end
      phase++;
      if (phase % 5 == 0) drain_queue();
    end

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("%0d result words checked over %0d random requests, peak fill %0d of %0d",
             checked, sent, peak, CAPACITY);
    $display("status codes hit, one bit per code from ok upward: %b", status_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
